// File: rtl/core/ohtab_pkg.sv
// shared types, constants and codes of the open addressing hash table
package ohtab_pkg;

    // table geometry
    localparam int SLOTS    = 1024;
    localparam int SLOT_W   = $clog2(SLOTS);
    localparam int COUNT_W  = SLOT_W + 1;
    localparam int KEY_W    = 32;
    localparam int FUNC_W   = 2;
    localparam int STATUS_W = 3;
    localparam int LOG2_W   = 4;

    // size_log2 saturation range
    localparam logic [LOG2_W-1:0] SIZE_LOG2_MIN   = LOG2_W'(6);
    localparam logic [LOG2_W-1:0] SIZE_LOG2_MAX   = LOG2_W'(SLOT_W);
    localparam logic [LOG2_W-1:0] SIZE_LOG2_RESET = LOG2_W'(10);

    // hash multiplier
    localparam logic [KEY_W-1:0] HASH_MULT = 32'h045d_9f3b;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = KEY_W;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_LOG2   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_INVALID_KEY = 1'b1;

    // operation codes
    localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_CREATE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd2;

    // slot tags
    typedef enum logic [1:0] {
        TAG_EMPTY    = 2'd0,
        TAG_OCCUPIED = 2'd1,
        TAG_DELETED  = 2'd2
    } t_tag;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_FOUND   = 3'd0,
        ST_CREATED = 3'd1,
        ST_REMOVED = 3'd2,
        ST_ABSENT  = 3'd3,
        ST_INVALID = 3'd4,
        ST_FULL    = 3'd5
    } t_status;

    // controller states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_PROBE,
        S_FINISH
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic clear;
        logic load;
        logic hash;
        logic probe;
        logic commit;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic clear_done;
        logic invalid;
        logic stop;
    } t_dp_status;

endpackage

// File: rtl/core/ohtab_req_if.sv
// request channel: operation code and key
interface ohtab_req_if import ohtab_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [KEY_W-1:0]  key;

    modport source(output valid, output func, output key, input ready);
    modport sink(input valid, input func, input key, output ready);
endinterface

// File: rtl/core/ohtab_rsp_if.sv
// response channel: status, slot handle, reuse flag and live count
interface ohtab_rsp_if import ohtab_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot_index;
    logic                reused_tombstone;
    logic [COUNT_W-1:0]  live_count;

    modport source(output valid, output status, output slot_index,
                   output reused_tombstone, output live_count, input ready);
    modport sink(input valid, input status, input slot_index,
                 input reused_tombstone, input live_count, output ready);
endinterface

// File: rtl/core/ohtab_ctrl.sv
// controller state machine: clearing pass, hashing, probe loop and result handoff
module ohtab_ctrl import ohtab_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_dp_cmd    o_cmd,
    input  t_dp_status i_st
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    // state and output valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // next state and commands
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        n_out_valid = r_out_valid & ~i_out_ready;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_st.clear_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_HASH;
                end
            end
            S_HASH: begin
                o_cmd.hash = 1'b1;
                n_state    = i_st.invalid ? S_FINISH : S_PROBE;
            end
            S_PROBE: begin
                o_cmd.probe = 1'b1;
                if (i_st.stop) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                // wait until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.commit = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

    // a word shows up only after a commit
    a_valid_after_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_FINISH))
        else $error("output word appeared without a commit");

    // nothing is produced during the clearing pass
    a_no_word_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !r_out_valid)
        else $error("output word during clearing pass");

    // a commit never overwrites a word still waiting
    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready && r_state == S_FINISH) |=> (r_state == S_FINISH))
        else $error("commit over a pending output word");

endmodule

// File: rtl/core/ohtab_dp.sv
// datapath: config registers, hash, slot stores, probe registers, counters, output word
module ohtab_dp import ohtab_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  t_dp_cmd               i_cmd,
    output t_dp_status            o_st,
    input  logic [FUNC_W-1:0]     i_func,
    input  logic [KEY_W-1:0]      i_key,
    output logic [STATUS_W-1:0]   o_status,
    output logic [SLOT_W-1:0]     o_slot_index,
    output logic                  o_reused_tombstone,
    output logic [COUNT_W-1:0]    o_live_count
);

    // slot stores
    t_tag       tag_mem [SLOTS];
    logic [KEY_W-1:0] key_mem [SLOTS];
    t_tag       r_tag_q;
    logic [KEY_W-1:0] r_key_q;

    // configuration
    logic [LOG2_W-1:0] r_size_log2;
    logic [KEY_W-1:0]  r_invalid_key;

    // operation and probe state
    logic [FUNC_W-1:0] r_func;
    logic [KEY_W-1:0]  r_key;
    logic [KEY_W-1:0]  r_prod;
    logic [SLOT_W-1:0] r_idx;
    logic [SLOT_W-1:0] r_step;
    logic              r_have_dead;
    logic [SLOT_W-1:0] r_dead;
    logic              r_hit;
    logic              r_saw_empty;
    logic [SLOT_W-1:0] r_stop_idx;
    logic [SLOT_W-1:0] r_clr_addr;

    // counters
    logic [COUNT_W-1:0] r_occ, n_occ;
    logic [COUNT_W-1:0] r_tomb, n_tomb;

    // output word
    t_status           r_out_status;
    logic [SLOT_W-1:0] r_out_slot;
    logic              r_out_reused;
    logic [COUNT_W-1:0] r_out_count;

    logic [LOG2_W-1:0]  size_log2_eff;
    logic [SLOT_W-1:0]  mask;
    logic [COUNT_W-1:0] size_val;
    logic [COUNT_W+2:0] size3;
    logic [COUNT_W:0]   used;
    logic               full;
    logic [KEY_W-1:0]   mix_in;
    logic [KEY_W-1:0]   prod;
    logic [KEY_W-1:0]   mix_out;
    logic [SLOT_W-1:0]  hash_idx;
    logic [SLOT_W-1:0]  next_idx;
    logic [SLOT_W-1:0]  rd_addr;
    logic               hit;
    logic               empty;
    logic               last;
    logic               invalid;

    t_status            res_status;
    logic [SLOT_W-1:0]  res_slot;
    logic               res_reused;
    logic [SLOT_W-1:0]  create_slot;
    logic               wr_tag_en;
    logic               wr_key_en;
    logic [SLOT_W-1:0]  wr_addr;
    t_tag               wr_tag;
    logic               mem_we;
    logic [SLOT_W-1:0]  mem_addr;
    t_tag               mem_tag;

    // configuration write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_log2   <= SIZE_LOG2_RESET;
            r_invalid_key <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SIZE_LOG2:   r_size_log2   <= i_cfg_wdata[LOG2_W-1:0];
                CFG_INVALID_KEY: r_invalid_key <= i_cfg_wdata[KEY_W-1:0];
            endcase
        end
    end

    // saturated table size and mask
    always_comb begin
        if (r_size_log2 < SIZE_LOG2_MIN) begin
            size_log2_eff = SIZE_LOG2_MIN;
        end else if (r_size_log2 > SIZE_LOG2_MAX) begin
            size_log2_eff = SIZE_LOG2_MAX;
        end else begin
            size_log2_eff = r_size_log2;
        end
    end

    assign mask     = ~({SLOT_W{1'b1}} << size_log2_eff);
    assign size_val = COUNT_W'(1) << size_log2_eff;
    assign size3    = (COUNT_W+3)'({size_val, 1'b0}) + (COUNT_W+3)'(size_val);
    assign used     = (COUNT_W+1)'(r_occ) + (COUNT_W+1)'(r_tomb);
    assign full     = (COUNT_W+3)'({used, 2'b00}) >= size3;

    // hash: xor-shift and multiply at load, xor-shift and mask in the hash cycle
    assign mix_in   = i_key ^ (i_key >> 16);
    assign prod     = mix_in * HASH_MULT;
    assign mix_out  = r_prod ^ (r_prod >> 16);
    assign hash_idx = mix_out[SLOT_W-1:0] & mask;

    // triangular probe: next slot is idx + step + 1
    assign next_idx = (r_idx + r_step + SLOT_W'(1)) & mask;
    assign rd_addr  = i_cmd.hash ? hash_idx : next_idx;

    // probe checks on the slot just read
    assign hit     = (r_tag_q == TAG_OCCUPIED) && (r_key_q == r_key);
    assign empty   = (r_tag_q == TAG_EMPTY);
    assign last    = (r_step == mask);
    assign invalid = (r_key == r_invalid_key) ||
                     !(r_func == FUNC_LOOKUP || r_func == FUNC_CREATE ||
                       r_func == FUNC_REMOVE);

    assign o_st.clear_done = (r_clr_addr == SLOT_W'(SLOTS - 1));
    assign o_st.invalid    = invalid;
    assign o_st.stop       = hit || empty || last;

    // operation registers and probe walk
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= i_func;
            r_key  <= i_key;
            r_prod <= prod;
        end
        if (i_cmd.hash) begin
            r_idx       <= hash_idx;
            r_step      <= '0;
            r_have_dead <= 1'b0;
        end
        if (i_cmd.probe) begin
            // remember the first tombstone on the path
            if (r_tag_q == TAG_DELETED && !r_have_dead) begin
                r_have_dead <= 1'b1;
                r_dead      <= r_idx;
            end
            if (o_st.stop) begin
                r_hit       <= hit;
                r_saw_empty <= empty;
                r_stop_idx  <= r_idx;
            end else begin
                r_idx  <= next_idx;
                r_step <= r_step + SLOT_W'(1);
            end
        end
    end

    // result of the finished operation
    assign create_slot = r_have_dead ? r_dead : r_stop_idx;

    always_comb begin
        res_status = ST_ABSENT;
        res_slot   = '0;
        res_reused = 1'b0;
        wr_tag_en  = 1'b0;
        wr_key_en  = 1'b0;
        wr_addr    = r_stop_idx;
        wr_tag     = TAG_OCCUPIED;
        n_occ      = r_occ;
        n_tomb     = r_tomb;
        if (invalid) begin
            res_status = ST_INVALID;
        end else begin
            case (r_func)
                FUNC_LOOKUP: begin
                    if (r_hit) begin
                        res_status = ST_FOUND;
                        res_slot   = r_stop_idx;
                    end
                end
                FUNC_CREATE: begin
                    if (r_hit) begin
                        res_status = ST_FOUND;
                        res_slot   = r_stop_idx;
                    end else if (full || (!r_saw_empty && !r_have_dead)) begin
                        res_status = ST_FULL;
                    end else begin
                        res_status = ST_CREATED;
                        res_slot   = create_slot;
                        res_reused = r_have_dead;
                        wr_tag_en  = 1'b1;
                        wr_key_en  = 1'b1;
                        wr_addr    = create_slot;
                        n_occ      = r_occ + COUNT_W'(1);
                        if (r_have_dead && r_tomb != '0) begin
                            n_tomb = r_tomb - COUNT_W'(1);
                        end
                    end
                end
                FUNC_REMOVE: begin
                    if (r_hit) begin
                        res_status = ST_REMOVED;
                        wr_tag_en  = 1'b1;
                        wr_tag     = TAG_DELETED;
                        n_tomb     = r_tomb + COUNT_W'(1);
                        if (r_occ != '0) begin
                            n_occ = r_occ - COUNT_W'(1);
                        end
                    end
                end
                default: begin
                    res_status = ST_INVALID;
                end
            endcase
        end
    end

    // tag store write port shared by clearing pass and commits
    assign mem_we   = i_cmd.clear || (i_cmd.commit && wr_tag_en);
    assign mem_addr = i_cmd.clear ? r_clr_addr : wr_addr;
    assign mem_tag  = i_cmd.clear ? TAG_EMPTY : wr_tag;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            tag_mem[mem_addr] <= mem_tag;
        end
        r_tag_q <= tag_mem[rd_addr];
    end

    // key store
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && wr_key_en) begin
            key_mem[wr_addr] <= r_key;
        end
        r_key_q <= key_mem[rd_addr];
    end

    // clearing pass address and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_occ      <= '0;
            r_tomb     <= '0;
        end else begin
            if (i_cmd.clear) begin
                r_clr_addr <= r_clr_addr + SLOT_W'(1);
            end
            if (i_cmd.commit) begin
                r_occ  <= n_occ;
                r_tomb <= n_tomb;
            end
        end
    end

    // output word
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_status <= res_status;
            r_out_slot   <= res_slot;
            r_out_reused <= res_reused;
            r_out_count  <= n_occ;
        end
    end

    assign o_status           = r_out_status;
    assign o_slot_index       = r_out_slot;
    assign o_reused_tombstone = r_out_reused;
    assign o_live_count       = r_out_count;

    // the probe walk never runs past the table size
    a_step_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.probe |-> (r_step <= mask))
        else $error("probe step beyond table size");

    // counters move only at a commit
    a_counts_on_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.commit |=> ($stable(r_occ) && $stable(r_tomb)))
        else $error("counter changed without a commit");

    // occupied plus deleted slots never exceed the store
    a_counts_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        used <= (COUNT_W+1)'(SLOTS))
        else $error("slot counters exceed table capacity");

endmodule

// File: rtl/core/open_addressing_hash_table_top.sv
// top level of the open addressing hash table with triangular probing and tombstones
//
//  channel   dir  handshake            payload
//  i_req     in   valid/ready          func[1:0], key[31:0]
//  o_rsp     out  valid/ready          status[2:0], slot_index[9:0],
//                                      reused_tombstone, live_count[10:0]
//  cfg       in   i_cfg_we (no wait)   i_cfg_idx[0], i_cfg_wdata[31:0]
//
//  an accepted word is hashed, then the probe loop reads one slot per cycle from the
//  tag and key stores until a hit, an empty slot or the end of the table (at most
//  the table size in slots); an invalid key or code skips the probe loop. the next
//  word is accepted once the result is committed to the output register. after
//  reset a clearing pass empties all 1024 slots of the tag store; no word is
//  accepted meanwhile, configuration writes are taken.
//  a result waits in the output register while the next word is accepted; the
//  next result is held back until the previous one is taken.
module open_addressing_hash_table_top import ohtab_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    ohtab_req_if.sink             i_req,
    ohtab_rsp_if.source           o_rsp
);

    t_dp_cmd    cmd;
    t_dp_status st;

    // controller
    ohtab_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .o_cmd       (cmd),
        .i_st        (st)
    );

    // datapath
    ohtab_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_wdata        (i_cfg_wdata),
        .i_cmd              (cmd),
        .o_st               (st),
        .i_func             (i_req.func),
        .i_key              (i_req.key),
        .o_status           (o_rsp.status),
        .o_slot_index       (o_rsp.slot_index),
        .o_reused_tombstone (o_rsp.reused_tombstone),
        .o_live_count       (o_rsp.live_count)
    );

endmodule

// File: tb/tb.sv
// self-checking testbench of the open addressing hash table top level
module tb import ohtab_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    // operation code outside the defined set
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    localparam int CLK_HALF      = 10;
    localparam int RESET_CYCLES  = 10;
    localparam int HOLD_CYCLES   = 400;
    localparam int QUIET_LIMIT   = 20000;
    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES   = 16;
    localparam int WRAP_SLOTS    = 64;
    localparam int MAX_REPORTS   = 40;
    localparam int FINAL_ITEMS   = 200;

    // random phases: size register value, item count, idle percentages, hold-off item
    localparam int PHASES = 6;
    localparam int PHASE_LOG2 [PHASES]     = '{6, 7, 3, 8, 9, 15};
    localparam int PHASE_ITEMS [PHASES]    = '{250, 200, 100, 250, 250, 250};
    localparam int PHASE_SRC_IDLE [PHASES] = '{36, 36, 54, 54, 0, 0};
    localparam int PHASE_SNK_IDLE [PHASES] = '{54, 54, 36, 36, 0, 0};
    localparam int PHASE_HOLD [PHASES]     = '{-1, -1, -1, -1, 60, -1};

    typedef struct packed {
        t_status            status;
        logic [SLOT_W-1:0]  slot_index;
        logic               reused_tombstone;
        logic [COUNT_W-1:0] live_count;
    } table_result_t;

    // shadow hash table and queue of results still to come
    class hash_table_scoreboard;
        t_tag              slot_tag [SLOTS];
        logic [KEY_W-1:0]  slot_key [SLOTS];
        int unsigned       live_slots;
        int unsigned       dead_slots;
        logic [LOG2_W-1:0] size_log2;
        logic [KEY_W-1:0]  invalid_key;
        table_result_t     expected_results [$];
        int unsigned       errors;
        int unsigned       checked;
        int unsigned       status_hits [8];
        int unsigned       reuse_hits;

        function new();
            foreach (slot_tag[i]) begin
                slot_tag[i] = TAG_EMPTY;
                slot_key[i] = '0;
            end
            foreach (status_hits[i]) status_hits[i] = 0;
            live_slots  = 0;
            dead_slots  = 0;
            size_log2   = SIZE_LOG2_RESET;
            invalid_key = '0;
            errors      = 0;
            checked     = 0;
            reuse_hits  = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_SIZE_LOG2) begin
                size_log2 = data[LOG2_W-1:0];
            end else begin
                invalid_key = data;
            end
        endfunction

        // slots in use, size register saturated to the supported range
        function int unsigned table_slots();
            int unsigned lg;
            lg = size_log2;
            if (lg > SIZE_LOG2_MAX) lg = SIZE_LOG2_MAX;
            if (lg < SIZE_LOG2_MIN) lg = SIZE_LOG2_MIN;
            return 1 << lg;
        endfunction

        // xor-shift, multiply, xor-shift, mask
        function int unsigned home_slot(logic [KEY_W-1:0] key, int unsigned mask);
            logic [KEY_W-1:0] h;
            h = key ^ (key >> 16);
            h = h * HASH_MULT;
            h = h ^ (h >> 16);
            return h & mask;
        endfunction

        // triangular probe for an occupied slot holding the key
        function bit locate(logic [KEY_W-1:0] key, int unsigned size,
                            output int unsigned where);
            int unsigned idx;
            idx   = home_slot(key, size - 1);
            where = 0;
            for (int unsigned n = 0; n < size; n++) begin
                if (slot_tag[idx] == TAG_EMPTY) return 1'b0;
                if (slot_tag[idx] == TAG_OCCUPIED && slot_key[idx] == key) begin
                    where = idx;
                    return 1'b1;
                end
                idx = (idx + n + 1) & (size - 1);
            end
            return 1'b0;
        endfunction

        // apply one accepted request word and queue its result
        function void note_request(logic [FUNC_W-1:0] func, logic [KEY_W-1:0] key);
            int unsigned   size;
            int unsigned   where;
            int unsigned   idx;
            int unsigned   tomb_at;
            bit            have_tomb;
            bit            have_spot;
            table_result_t want;

            size                  = table_slots();
            want.status           = ST_INVALID;
            want.slot_index       = '0;
            want.reused_tombstone = 1'b0;
            where                 = 0;
            if (key == invalid_key || func == FUNC_UNUSED) begin
                want.status = ST_INVALID;
            end else if (func == FUNC_REMOVE) begin
                if (locate(key, size, where)) begin
                    slot_tag[where] = TAG_DELETED;
                    if (live_slots > 0) live_slots--;
                    dead_slots++;
                    want.status = ST_REMOVED;
                end else begin
                    want.status = ST_ABSENT;
                end
            end else if (locate(key, size, where)) begin
                want.status     = ST_FOUND;
                want.slot_index = SLOT_W'(where);
            end else if (func == FUNC_LOOKUP) begin
                want.status = ST_ABSENT;
            end else if ((live_slots + dead_slots) * 4 >= size * 3) begin
                want.status = ST_FULL;
            end else begin
                // first tombstone on the probe path wins, else the empty slot ending it
                idx       = home_slot(key, size - 1);
                have_tomb = 1'b0;
                have_spot = 1'b0;
                tomb_at   = 0;
                for (int unsigned n = 0; n < size; n++) begin
                    if (slot_tag[idx] == TAG_DELETED && !have_tomb) begin
                        have_tomb = 1'b1;
                        tomb_at   = idx;
                    end
                    if (slot_tag[idx] == TAG_EMPTY) begin
                        have_spot = 1'b1;
                        where     = have_tomb ? tomb_at : idx;
                        break;
                    end
                    idx = (idx + n + 1) & (size - 1);
                end
                if (!have_spot && have_tomb) begin
                    have_spot = 1'b1;
                    where     = tomb_at;
                end
                if (!have_spot) begin
                    want.status = ST_FULL;
                end else begin
                    want.reused_tombstone = (slot_tag[where] == TAG_DELETED);
                    if (want.reused_tombstone && dead_slots > 0) dead_slots--;
                    slot_tag[where] = TAG_OCCUPIED;
                    slot_key[where] = key;
                    live_slots++;
                    want.status     = ST_CREATED;
                    want.slot_index = SLOT_W'(where);
                end
            end
            want.live_count = COUNT_W'(live_slots);
            status_hits[want.status]++;
            if (want.reused_tombstone) reuse_hits++;
            expected_results.push_back(want);
        endfunction

        // compare one accepted response word with the oldest expected result
        function void check_response(t_status status, logic [SLOT_W-1:0] slot_index,
                                     logic reused, logic [COUNT_W-1:0] live);
            table_result_t want;
            checked++;
            if (expected_results.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: result with none outstanding: status %0d slot %0d reused %0d live %0d",
                             $time, status, slot_index, reused, live);
                return;
            end
            want = expected_results.pop_front();
            if (want.status !== status || want.slot_index !== slot_index ||
                want.reused_tombstone !== reused || want.live_count !== live) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: mismatch expected status %0d slot %0d reused %0d live %0d, got status %0d slot %0d reused %0d live %0d",
                             $time, want.status, want.slot_index, want.reused_tombstone,
                             want.live_count, status, slot_index, reused, live);
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    ohtab_req_if req_ch ();
    ohtab_rsp_if rsp_ch ();

    int                   src_idle_pct = 0;
    int                   snk_idle_pct = 0;
    bit                   hold_rsp     = 1'b0;
    logic [KEY_W-1:0]     key_pool [$];
    hash_table_scoreboard sb = new();

    open_addressing_hash_table_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_ch),
        .o_rsp       (rsp_ch)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    // response ready: random stalls, and one long hold-off when asked
    initial begin
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_rsp) begin
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_rsp = 1'b0;
            end else begin
                rsp_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
            end
        end
    end

    // sample both channels at the rising edge
    always @(posedge i_clk) begin
        if (req_ch.valid && req_ch.ready) sb.note_request(req_ch.func, req_ch.key);
        if (rsp_ch.valid && rsp_ch.ready)
            sb.check_response(t_status'(rsp_ch.status), rsp_ch.slot_index,
                              rsp_ch.reused_tombstone, rsp_ch.live_count);
    end

    // watchdog on cycles without any handshake
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) quiet = 0;
            else quiet++;
        end
        $display("%0t: watchdog: no handshake for %0d cycles", $time, QUIET_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    // drive one request word and wait until it is taken
    task automatic send_word(logic [FUNC_W-1:0] func, logic [KEY_W-1:0] key);
        while ($urandom_range(99) < src_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.func  <= func;
        req_ch.key   <= key;
        @(posedge i_clk);
        while (req_ch.ready !== 1'b1) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // stop sending and let every outstanding operation finish
    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        while (sb.expected_results.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // one register write, mirrored into the shadow table
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        sb.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // size write with random upper data bits
    task automatic set_size(logic [LOG2_W-1:0] log2);
        logic [CFG_DATA_W-1:0] data;
        data              = $urandom;
        data[LOG2_W-1:0]  = log2;
        write_reg(CFG_SIZE_LOG2, data);
    endtask

    // new key pool, about half carried over so older entries keep getting hit
    function automatic void refresh_pool(int unsigned target);
        logic [KEY_W-1:0] fresh [$];
        while (fresh.size() < target) begin
            if (key_pool.size() != 0 && $urandom_range(1) == 1)
                fresh.push_back(key_pool[$urandom_range(key_pool.size() - 1)]);
            else
                fresh.push_back($urandom);
        end
        key_pool = fresh;
    endfunction

    // random mix of operations, keys mostly from the pool
    task automatic run_phase(int count, int hold_at);
        int unsigned       pick;
        logic [FUNC_W-1:0] func;
        logic [KEY_W-1:0]  key;
        for (int i = 0; i < count; i++) begin
            if (i == hold_at) hold_rsp = 1'b1;
            pick = $urandom_range(99);
            if (pick < 3) func = FUNC_UNUSED;
            else if (pick < 48) func = FUNC_CREATE;
            else if (pick < 75) func = FUNC_LOOKUP;
            else func = FUNC_REMOVE;
            pick = $urandom_range(99);
            if (pick < 3) key = sb.invalid_key;
            else if (pick < 15) key = $urandom;
            else key = key_pool[$urandom_range(key_pool.size() - 1)];
            send_word(func, key);
        end
    endtask

    // stimulus
    initial begin
        logic [KEY_W-1:0] key;

        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = '0;
        i_cfg_wdata  = '0;
        req_ch.valid = 1'b0;
        req_ch.func  = FUNC_LOOKUP;
        req_ch.key   = '0;
        src_idle_pct = PHASE_SRC_IDLE[0];
        snk_idle_pct = PHASE_SNK_IDLE[0];
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: create, find, remove, tombstone reuse and rejected words
        set_size(LOG2_W'(6));
        write_reg(CFG_INVALID_KEY, 32'hFFFF_FFFF);
        send_word(FUNC_CREATE, 32'h0000_0001);
        send_word(FUNC_CREATE, 32'hFFFF_FFFE);
        send_word(FUNC_CREATE, 32'h8000_0000);
        send_word(FUNC_CREATE, 32'h0000_0000);
        send_word(FUNC_LOOKUP, 32'h0000_0001);
        send_word(FUNC_CREATE, 32'h0000_0001);
        send_word(FUNC_REMOVE, 32'h0000_0001);
        send_word(FUNC_LOOKUP, 32'h0000_0001);
        send_word(FUNC_REMOVE, 32'h0000_0001);
        send_word(FUNC_CREATE, 32'h0000_0001);
        send_word(FUNC_CREATE, 32'hFFFF_FFFF);
        send_word(FUNC_LOOKUP, 32'hFFFF_FFFF);
        send_word(FUNC_REMOVE, 32'hFFFF_FFFF);
        send_word(FUNC_UNUSED, 32'h0000_0001);
        send_word(FUNC_UNUSED, 32'hFFFF_FFFF);
        send_word(FUNC_LOOKUP, 32'h7FFF_FFFF);
        send_word(FUNC_REMOVE, 32'h0000_0000);
        send_word(FUNC_LOOKUP, 32'h0000_0000);
        wait_idle();

        // all-zero key becomes the rejected one
        write_reg(CFG_INVALID_KEY, 32'h0000_0000);
        send_word(FUNC_CREATE, 32'h0000_0000);
        send_word(FUNC_CREATE, 32'hFFFF_FFFF);
        send_word(FUNC_LOOKUP, 32'hFFFF_FFFF);
        send_word(FUNC_REMOVE, 32'hFFFF_FFFE);
        wait_idle();

        // random phases over tables of varied sizes, contents kept across resizes
        for (int p = 0; p < PHASES; p++) begin
            src_idle_pct = PHASE_SRC_IDLE[p];
            snk_idle_pct = PHASE_SNK_IDLE[p];
            set_size(LOG2_W'(PHASE_LOG2[p]));
            refresh_pool(sb.table_slots() * 5 / 4);
            if ($urandom_range(1) == 1)
                write_reg(CFG_INVALID_KEY, key_pool[$urandom_range(key_pool.size() - 1)]);
            else
                write_reg(CFG_INVALID_KEY, $urandom);
            run_phase(PHASE_ITEMS[p], PHASE_HOLD[p]);
            wait_idle();
        end

        // fill every low slot so the smallest table has no empty slot to stop a probe
        set_size(LOG2_W'(10));
        for (int s = 0; s < WRAP_SLOTS; s++) begin
            if (sb.slot_tag[s] == TAG_EMPTY) begin
                key = $urandom;
                while (sb.home_slot(key, SLOTS - 1) != s || key == sb.invalid_key)
                    key = $urandom;
                send_word(FUNC_CREATE, key);
            end
        end
        wait_idle();

        // smallest table over stranded entries, probes that find no match run the full length
        set_size(LOG2_W'(0));
        refresh_pool(sb.table_slots() * 5 / 4);
        run_phase(FINAL_ITEMS, -1);
        wait_idle();
        repeat (TAIL_CYCLES) @(negedge i_clk);

        $display("checked %0d results on tables of 64 to 1024 slots: %0d found, %0d created (%0d in tombstones)",
                 sb.checked, sb.status_hits[ST_FOUND], sb.status_hits[ST_CREATED], sb.reuse_hits);
        $display("%0d removed, %0d absent, %0d rejected keys or codes, %0d refused as full",
                 sb.status_hits[ST_REMOVED], sb.status_hits[ST_ABSENT],
                 sb.status_hits[ST_INVALID], sb.status_hits[ST_FULL]);
        if (sb.errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
